FILE: rtl/nlsw_pkg.sv
package nlsw_pkg;

  localparam int LINE_CAPACITY_DEF = 48;

  localparam int HDR_LEN  = 9;
  localparam int TAIL_LEN = 5;
  localparam int POS_W    = 4;

  localparam logic [7:0] NL_BYTE     = 8'h0A;
  localparam logic [7:0] CR_BYTE     = 8'h0D;
  localparam logic [7:0] STAR_BYTE   = 8'h2A;
  localparam logic [7:0] APOS_BYTE   = 8'h27;
  localparam logic [7:0] DOLLAR_BYTE = 8'h24;

  // Tail positions after the payload.
  localparam logic [POS_W-1:0] TAIL_STAR = 4'd0;
  localparam logic [POS_W-1:0] TAIL_HI   = 4'd1;
  localparam logic [POS_W-1:0] TAIL_LO   = 4'd2;
  localparam logic [POS_W-1:0] TAIL_CR   = 4'd3;
  localparam logic [POS_W-1:0] TAIL_LF   = 4'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_item_t;

  // Fixed sentence header (talker, type and message field), one byte per index.
  function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h50;
      4'd1:    b = 8'h4D;
      4'd2:    b = 8'h56;
      4'd3:    b = 8'h52;
      4'd4:    b = 8'h2C;
      4'd5:    b = 8'h4D;
      4'd6:    b = 8'h53;
      4'd7:    b = 8'h47;
      4'd8:    b = 8'h2C;
      default: b = 8'h2C;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] b;
    if (d < 4'd10) begin
      b = 8'h30 + {4'd0, d};
    end else begin
      b = 8'h37 + {4'd0, d};
    end
    return b;
  endfunction

endpackage

FILE: rtl/nlsw_out_stage.sv
module nlsw_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  nlsw_pkg::out_item_t push_item,
  output logic              push_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // out_byte[7:0]
  output logic              out_tlast    // last_of_run
);
  import nlsw_pkg::*;

  out_item_t  buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = buf_r[rd_ptr_r].data;
  assign out_tlast  = buf_r[rd_ptr_r].last;

  assign do_push = push_valid && push_ready;
  assign do_pop  = out_tvalid && out_tready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/nmea_line_sentence_wrapper.sv
// Byte stream to NMEA 0183 sentence framer. With wrap_enable low every input
// item is forwarded as one output item with tlast set, one item per cycle as
// long as the output side keeps up. With wrap_enable high, bytes are collected
// in a line memory of LINE_CAPACITY-1 entries (one item per cycle, extra bytes
// are dropped) and a newline turns the line into "$<header><payload>*HH<CR><LF>",
// where '*' in the payload becomes an apostrophe and HH is the XOR checksum.
// While a sentence is sent the input is stalled: the header and tail bytes are
// pushed one by one, each payload byte takes a memory read and then an output
// push, and output back-pressure adds to the stall. A trailing CR before the
// newline is discarded, and an empty line produces nothing. Writing the
// configuration channel sets the mode and empties the line memory.
module nmea_line_sentence_wrapper #(
  parameter int LINE_CAPACITY = nlsw_pkg::LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // in_byte[7:0]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // out_byte[7:0]
  output logic       out_tlast,    // last_of_run
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data      // wrap_enable
);
  import nlsw_pkg::*;

  localparam int DEPTH = LINE_CAPACITY - 1;
  localparam int CNT_W = $clog2(LINE_CAPACITY);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_RD   = 5'b00100,
    S_PAY  = 5'b01000,
    S_TAIL = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic             wrap_r, wrap_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             last_cr_r, last_cr_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] addr_r, addr_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_q_r;
  logic             mem_we, mem_re;

  logic             in_acc, cfg_acc;
  logic             push_valid, push_ready;
  out_item_t        push_item;
  logic [7:0]       pay_byte;
  logic [CNT_W-1:0] line_len;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = (state_r == S_IDLE) && (wrap_r || push_ready);
  assign in_acc    = in_tvalid && in_tready;

  assign mem_we   = in_acc && wrap_r && (in_tdata != NL_BYTE) && (count_r < CNT_W'(DEPTH));
  assign mem_re   = (state_r == S_RD);
  assign pay_byte = (mem_q_r == STAR_BYTE) ? APOS_BYTE : mem_q_r;
  // A final CR is only taken off the length when the line holds at least one byte.
  assign line_len = count_r - {{(CNT_W-1){1'b0}}, (last_cr_r && (count_r != '0))};

  always_comb begin
    state_nxt   = state_r;
    wrap_nxt    = wrap_r;
    count_nxt   = count_r;
    last_cr_nxt = last_cr_r;
    len_nxt     = len_r;
    addr_nxt    = addr_r;
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    push_valid  = 1'b0;
    push_item   = '{data: in_tdata, last: 1'b1};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!wrap_r) begin
            push_valid = 1'b1;
          end else if (in_tdata != NL_BYTE) begin
            if (mem_we) begin
              count_nxt   = count_r + 1'b1;
              last_cr_nxt = (in_tdata == CR_BYTE);
            end
          end else begin
            count_nxt = '0;
            if (line_len != '0) begin
              len_nxt   = line_len;
              pos_nxt   = '0;
              sum_nxt   = 8'h00;
              state_nxt = S_HDR;
            end
          end
        end
      end
      S_HDR: begin
        push_valid = 1'b1;
        push_item  = '{data: (pos_r == '0) ? DOLLAR_BYTE : hdr_byte(pos_r - 1'b1),
                       last: 1'b0};
        if (push_ready) begin
          if (pos_r != '0) begin
            sum_nxt = sum_r ^ push_item.data;
          end
          if (pos_r == POS_W'(HDR_LEN)) begin
            addr_nxt  = '0;
            state_nxt = S_RD;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      S_RD: begin
        state_nxt = S_PAY;
      end
      S_PAY: begin
        push_valid = 1'b1;
        push_item  = '{data: pay_byte, last: 1'b0};
        if (push_ready) begin
          sum_nxt  = sum_r ^ pay_byte;
          addr_nxt = addr_r + 1'b1;
          if (addr_nxt == len_r) begin
            pos_nxt   = TAIL_STAR;
            state_nxt = S_TAIL;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_TAIL: begin
        push_valid = 1'b1;
        case (pos_r)
          TAIL_STAR: push_item = '{data: STAR_BYTE, last: 1'b0};
          TAIL_HI:   push_item = '{data: hex_digit(sum_r[7:4]), last: 1'b0};
          TAIL_LO:   push_item = '{data: hex_digit(sum_r[3:0]), last: 1'b0};
          TAIL_CR:   push_item = '{data: CR_BYTE, last: 1'b0};
          default:   push_item = '{data: NL_BYTE, last: 1'b1};
        endcase
        if (push_ready) begin
          if (pos_r == POS_W'(TAIL_LEN - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_acc) begin
      wrap_nxt  = cfg_data;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wrap_r    <= 1'b0;
      count_r   <= '0;
      last_cr_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wrap_r    <= wrap_nxt;
      count_r   <= count_nxt;
      last_cr_r <= last_cr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    addr_r <= addr_nxt;
    pos_r  <= pos_nxt;
    sum_r  <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= in_tdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[addr_r[IDX_W-1:0]];
    end
  end

  nlsw_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
